FILE: rtl/mrt_pkg.sv
// ----------------------------------------------------------------------------
// mrt_pkg
// Shared types, constants and the Mac OS Roman code point table.
// ----------------------------------------------------------------------------
package mrt_pkg;

  localparam int unsigned TABLE_ENTRIES = 128;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned CP_W          = 21;
  localparam int unsigned CNT_W         = 8;

  localparam logic [7:0] SUB_CHAR    = 8'h1A;
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_CODE  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_CODE  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK  = 8'hF8;
  localparam logic [7:0] LEAD4_CODE  = 8'hF0;
  localparam logic [7:0] CONT_MASK   = 8'hC0;
  localparam logic [7:0] CONT_CODE   = 8'h80;
  localparam logic [7:0] LEAD2_DATA  = 8'h1F;
  localparam logic [7:0] LEAD3_DATA  = 8'h0F;
  localparam logic [7:0] LEAD4_DATA  = 8'h07;

  // Unicode point of Mac Roman characters 0x80 .. 0xFF
  localparam logic [15:0] ROMAN_HI [TABLE_ENTRIES] = '{
    16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
    16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
    16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
    16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
    16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
    16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
    16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
    16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
    16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
    16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
    16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
    16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
    16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
    16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
    16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
    16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
  };

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_EMIT   = 3'b100
  } mrt_state_e;

  typedef struct packed {
    logic            start;
    logic [CP_W-1:0] code;
  } search_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] out_byte;
  } search_rsp_t;

endpackage

FILE: rtl/mrt_if.sv
// ----------------------------------------------------------------------------
// mrt_if
// Request channels: UTF-8 byte in, Mac Roman byte out.
// ----------------------------------------------------------------------------
interface mrt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       final_byte;

  modport source (output valid, output in_byte, output final_byte, input ready);
  modport sink   (input valid, input in_byte, input final_byte, output ready);
endinterface

interface mrt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       done_res;
  logic       input_ok;
  logic [7:0] out_count;

  modport source (output valid, output out_byte, output done_res, output input_ok,
                  output out_count, input ready);
  modport sink   (input valid, input out_byte, input done_res, input input_ok,
                  input out_count, output ready);
endinterface

FILE: rtl/mrt_search.sv
// ----------------------------------------------------------------------------
// mrt_search
// Walks the Mac Roman table one entry a cycle with a single comparator.
// ----------------------------------------------------------------------------
module mrt_search
  import mrt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  search_req_t req_i,
  output search_rsp_t rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CP_W-1:0]  code_q, code_d;
  logic [7:0]       res_q, res_d;
  logic             hit;

  assign hit = ({{(CP_W-16){1'b0}}, ROMAN_HI[idx_q]} == code_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    idx_d  = idx_q;
    code_d = code_q;
    res_d  = res_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      idx_d  = '0;
      code_d = req_i.code;
    end else if (busy_q) begin
      if (hit) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = {1'b1, idx_q};
      end else if (idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = SUB_CHAR;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    res_q  <= res_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.out_byte = res_q;

endmodule

FILE: rtl/utf8_to_mac_roman_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_to_mac_roman_transcoder
// UTF-8 byte stream decoder emitting one Mac OS Roman byte per code point.
// ----------------------------------------------------------------------------
// Output: the result of an ASCII byte, an error or a sequence decoding below
//   0x80 is registered in the cycle after the request; a non-ASCII point goes
//   through the table search unit, one of 128 entries per cycle, then ST_EMIT.
// Throughput: one request per cycle while idle with the output free; none in a search.
// Reset: rst_ni clears the decode state, byte count and output valid at once.
module utf8_to_mac_roman_transcoder
  import mrt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  mrt_in_if.sink    in_i,
  mrt_out_if.source out_o
);

  mrt_state_e       st_q, st_d;
  logic [CP_W-1:0]  accum_q, accum_d;
  logic [1:0]       pend_q, pend_d;
  logic             drop_q, drop_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             fin_q, fin_d;
  logic [7:0]       res_q, res_d;

  logic             ov_q;
  logic [7:0]       ob_q;
  logic             od_q, ook_q;
  logic [CNT_W-1:0] oc_q;

  logic             out_free, in_acc;
  logic             emit, e_done, e_ok, e_fail, e_fin;
  logic [7:0]       e_byte;
  logic [CNT_W-1:0] cnt_inc;
  logic [CP_W-1:0]  accum_sh;
  logic [7:0]       b;
  search_req_t      sreq;
  search_rsp_t      srsp;

  mrt_search u_search (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (sreq),
    .rsp_o (srsp)
  );

  assign out_free   = !ov_q || out_o.ready;
  assign in_i.ready = (st_q == ST_IDLE) && out_free;
  assign in_acc     = in_i.valid && in_i.ready;
  assign b          = in_i.in_byte;
  assign accum_sh   = {accum_q[CP_W-7:0], b[5:0]};
  assign cnt_inc    = cnt_q + 1'b1;

  always_comb begin
    st_d       = st_q;
    accum_d    = accum_q;
    pend_d     = pend_q;
    drop_d     = drop_q;
    cnt_d      = cnt_q;
    fin_d      = fin_q;
    res_d      = res_q;
    emit       = 1'b0;
    e_byte     = SUB_CHAR;
    e_done     = 1'b0;
    e_ok       = 1'b0;
    e_fail     = 1'b0;
    e_fin      = in_i.final_byte;
    sreq.start = 1'b0;
    sreq.code  = accum_q;

    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (drop_q) begin
            if (in_i.final_byte) begin
              drop_d  = 1'b0;
              accum_d = '0;
              pend_d  = '0;
              cnt_d   = '0;
            end
          end else if (pend_q == 2'd0) begin
            if (!b[7]) begin
              emit   = 1'b1;
              e_byte = b;
              e_done = in_i.final_byte;
              e_ok   = 1'b1;
            end else if ((b & LEAD2_MASK) == LEAD2_CODE ||
                         (b & LEAD3_MASK) == LEAD3_CODE ||
                         (b & LEAD4_MASK) == LEAD4_CODE) begin
              if (in_i.final_byte) begin
                e_fail = 1'b1;
              end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
                pend_d  = 2'd1;
                accum_d = CP_W'(b & LEAD2_DATA);
              end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
                pend_d  = 2'd2;
                accum_d = CP_W'(b & LEAD3_DATA);
              end else begin
                pend_d  = 2'd3;
                accum_d = CP_W'(b & LEAD4_DATA);
              end
            end else begin
              e_fail = 1'b1;
            end
          end else if ((b & CONT_MASK) != CONT_CODE) begin
            e_fail = 1'b1;
          end else begin
            accum_d = accum_sh;
            pend_d  = pend_q - 2'd1;
            if (pend_q == 2'd1) begin
              if (accum_sh[CP_W-1:7] == '0) begin
                emit   = 1'b1;
                e_byte = {1'b0, accum_sh[6:0]};
                e_done = in_i.final_byte;
                e_ok   = 1'b1;
              end else begin
                sreq.start = 1'b1;
                sreq.code  = accum_sh;
                fin_d      = in_i.final_byte;
                st_d       = ST_SEARCH;
              end
            end else if (in_i.final_byte) begin
              e_fail = 1'b1;
            end
          end
        end
      end
      ST_SEARCH: begin
        if (srsp.done) begin
          res_d = srsp.out_byte;
          st_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        e_fin = fin_q;
        if (out_free) begin
          emit   = 1'b1;
          e_byte = res_q;
          e_done = fin_q;
          e_ok   = 1'b1;
          st_d   = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    if (e_fail) begin
      emit   = 1'b1;
      e_byte = SUB_CHAR;
      e_done = 1'b1;
      e_ok   = 1'b0;
    end

    if (emit) begin
      cnt_d = e_done ? '0 : cnt_inc;
      if (e_done) begin
        accum_d = '0;
        pend_d  = '0;
        drop_d  = e_fail && !e_fin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      accum_q <= '0;
      pend_q  <= '0;
      drop_q  <= 1'b0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      accum_q <= accum_d;
      pend_q  <= pend_d;
      drop_q  <= drop_d;
      cnt_q   <= cnt_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q <= fin_d;
    res_q <= res_d;
    if (emit) begin
      ob_q  <= e_byte;
      od_q  <= e_done;
      ook_q <= e_done && e_ok;
      oc_q  <= cnt_inc;
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.out_byte  = ob_q;
  assign out_o.done_res  = od_q;
  assign out_o.input_ok  = ook_q;
  assign out_o.out_count = oc_q;

endmodule

FILE: rtl/mrt_checker.sv
// ----------------------------------------------------------------------------
// mrt_checker
// Port-level checks on the transcoder, bound to the top level.
// ----------------------------------------------------------------------------
module mrt_checker
  import mrt_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       done_res_i,
  input logic       input_ok_i,
  input logic [7:0] out_count_i
);

  // async reset empties the output register; seen from the edge after
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("output valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
      $stable(done_res_i) && $stable(input_ok_i) && $stable(out_count_i))
    else $error("stalled output request changed");

  a_ok_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && input_ok_i |-> done_res_i)
    else $error("input_ok set on a non-final byte");

  // an invalid string always ends with the substitute character
  a_bad_is_sub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && done_res_i && !input_ok_i |-> out_byte_i == SUB_CHAR)
    else $error("invalid string ended without substitute character");

endmodule

bind utf8_to_mac_roman_transcoder mrt_checker u_mrt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_byte_i (out_o.out_byte),
  .done_res_i (out_o.done_res),
  .input_ok_i (out_o.input_ok),
  .out_count_i(out_o.out_count)
);
